// File: hw/rtl/mwm_pkg.sv
package mwm_pkg;

    // fixed field widths
    localparam int FIELD_W    = 16;
    localparam int SUM_W      = FIELD_W + 2;    // x +/- y +/- z, signed
    localparam int MAG_W      = FIELD_W + 1;    // |sum| <= 3 * 2^15
    localparam int NUM_WHEELS = 4;
    localparam int DUTY_W     = 8;
    localparam int DIR_W      = 2;
    localparam int WHEEL_W    = DUTY_W + DIR_W;
    localparam int DZ_W       = 8;
    localparam int TMO_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 3 * FIELD_W;
    localparam int OUT_DATA_W = NUM_WHEELS * WHEEL_W;

    localparam int SPEED_FRAC_BITS_DEF = 12;
    localparam int DUTY_BITS_DEF       = 8;

    // input beat kinds, carried on s_tuser
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // wheel direction codes
    localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

    localparam logic [DZ_W-1:0]  DEADZONE_RST = 8'd20;
    localparam logic [TMO_W-1:0] TIMEOUT_RST  = 16'd500;

    // wheel order: rear left, rear right, front left, front right
    // bit set: that term is subtracted for the wheel
    localparam logic [NUM_WHEELS-1:0] Y_SUB = 4'b0110;
    localparam logic [NUM_WHEELS-1:0] Z_SUB = 4'b0101;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

    typedef struct packed {
        logic tick;
        logic cmd;
    } wdog_req_t;

endpackage

// File: hw/rtl/mwm_mix.sv
module mwm_mix
    import mwm_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       load,
    input  logic signed [FIELD_W-1:0]  lin_x,
    input  logic signed [FIELD_W-1:0]  lin_y,
    input  logic signed [FIELD_W-1:0]  ang_z,
    output logic        [MAG_W-1:0]    mag [NUM_WHEELS],
    output logic        [NUM_WHEELS-1:0] neg,
    output logic        [MAG_W-1:0]    denom
);

    localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(1) << SPEED_FRAC_BITS;

    logic signed [SUM_W-1:0] xe;
    logic signed [SUM_W-1:0] ye;
    logic signed [SUM_W-1:0] ze;
    logic signed [SUM_W-1:0] sum  [NUM_WHEELS];
    logic signed [SUM_W-1:0] absv [NUM_WHEELS];

    logic [MAG_W-1:0]      mag_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg_reg;
    logic [MAG_W-1:0]      denom_reg;
    logic [MAG_W-1:0]      denom_next;
    logic [MAG_W-1:0]      max01;
    logic [MAG_W-1:0]      max23;
    logic [MAG_W-1:0]      max_all;

    assign xe = {{(SUM_W-FIELD_W){lin_x[FIELD_W-1]}}, lin_x};
    assign ye = {{(SUM_W-FIELD_W){lin_y[FIELD_W-1]}}, lin_y};
    assign ze = {{(SUM_W-FIELD_W){ang_z[FIELD_W-1]}}, ang_z};

    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            sum[i]  = xe + (Y_SUB[i] ? -ye : ye) + (Z_SUB[i] ? -ze : ze);
            absv[i] = sum[i][SUM_W-1] ? -sum[i] : sum[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                mag_reg[i] <= absv[i][MAG_W-1:0];
                neg_reg[i] <= sum[i][SUM_W-1];
            end
        end
    end

    // largest magnitude, never below full scale; registered from mag_reg after load
    always_comb
    begin
        max01      = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        max23      = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
        max_all    = (max01 > max23) ? max01 : max23;
        denom_next = (max_all > FULL_SCALE) ? max_all : FULL_SCALE;
    end

    always_ff @(posedge clk)
    begin
        denom_reg <= denom_next;
    end

    assign mag   = mag_reg;
    assign neg   = neg_reg;
    assign denom = denom_reg;

endmodule

// File: hw/rtl/mwm_lane.sv
module mwm_lane
    import mwm_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
)
(
    input  logic              clk,
    input  lane_ctl_t         ctl,
    input  logic [MAG_W-1:0]  mag,
    input  logic              neg,
    input  logic [MAG_W-1:0]  denom,
    input  logic [DZ_W-1:0]   deadzone,
    output logic [DUTY_W-1:0] duty,
    output logic [DIR_W-1:0]  dir
);

    localparam int NUM_W = MAG_W + DUTY_BITS;
    localparam int DXW   = (DUTY_BITS > DZ_W) ? DUTY_BITS : DZ_W;

    logic [MAG_W-1:0]     rem_reg, rem_next;
    logic [DUTY_BITS-1:0] lo_reg, lo_next;
    logic [DUTY_BITS-1:0] quo_reg, quo_next;
    logic [NUM_W-1:0]     num;
    logic [MAG_W:0]       trial;
    logic [MAG_W+1:0]     diff;
    logic                 ge;
    logic [DXW-1:0]       duty_ext;
    logic [DXW-1:0]       dz_ext;

    // numerator = mag * (2^DUTY_BITS - 1); quotient always fits DUTY_BITS
    assign num   = {mag, DUTY_BITS'(0)} - NUM_W'(mag);
    assign trial = {rem_reg, lo_reg[DUTY_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, denom};
    assign ge    = !diff[MAG_W+1];

    // restoring divide, one quotient bit per beat of step
    always_comb
    begin
        rem_next = rem_reg;
        lo_next  = lo_reg;
        quo_next = quo_reg;
        if (ctl.load)
        begin
            rem_next = num[NUM_W-1:DUTY_BITS];
            lo_next  = num[DUTY_BITS-1:0];
            quo_next = '0;
        end
        else if (ctl.step)
        begin
            rem_next = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            lo_next  = lo_reg << 1;
            quo_next = {quo_reg[DUTY_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign duty_ext = DXW'(quo_reg);
    assign dz_ext   = DXW'(deadzone);

    always_comb
    begin
        if (mag == '0 || duty_ext < dz_ext)
        begin
            duty = '0;
            dir  = DIR_BRAKE;
        end
        else
        begin
            duty = duty_ext[DUTY_W-1:0];
            dir  = neg ? DIR_REV : DIR_FWD;
        end
    end

endmodule

// File: hw/rtl/mwm_wdog.sv
module mwm_wdog
    import mwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  wdog_req_t        req,
    input  logic [TMO_W-1:0] timeout,
    output logic             fire
);

    logic [TMO_W-1:0] elapsed_reg, elapsed_next;
    logic             stopped_reg, stopped_next;
    logic [TMO_W-1:0] elapsed_inc;

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TMO_W'(1);
    assign fire        = req.tick && (elapsed_inc > timeout) && !stopped_reg;

    always_comb
    begin
        elapsed_next = elapsed_reg;
        stopped_next = stopped_reg;
        if (req.cmd)
        begin
            elapsed_next = '0;
            stopped_next = 1'b0;
        end
        else if (req.tick)
        begin
            elapsed_next = elapsed_inc;
            stopped_next = stopped_reg | fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            stopped_reg <= stopped_next;
        end
    end

    // stop fires once per silence
    a_fire_sets_stop: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> stopped_reg)
        else $error("watchdog stop not latched");

    a_cmd_clears: assert property (@(posedge clk) disable iff (!rst_n)
        req.cmd |=> (elapsed_reg == '0) && !stopped_reg)
        else $error("command did not clear watchdog");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && !req.cmd |=> stopped_reg && !fire)
        else $error("watchdog stop repeated or dropped");

endmodule

// File: hw/rtl/mecanum_wheel_mixer_watchdog_unit.sv
// Mecanum X-drive mixer with a command watchdog. An input beat is either a
// velocity command (s_tuser 0) or a one millisecond tick (s_tuser 1). A command
// gives one result beat with four wheel duties and directions, normalized when
// the largest wheel speed passes full scale. A taken command passes through the mix
// registers, ST_MIX (lane load), ST_DIV and ST_DONE; the result is loaded from
// ST_DONE once the output register is free, and only then can the next beat be
// taken. The four bit-serial dividers resolve one duty bit per cycle in parallel.
// A tick leaves the unit idle and gives a result beat (all brake, m_tuser 1) only the
// first time the count of ticks since the last command exceeds timeout_ms. A new
// beat is taken once the previous one is done and the output register is free or
// being drained.
module mecanum_wheel_mixer_watchdog_unit
    import mwm_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF,
    parameter int DUTY_BITS       = DUTY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // lin_x, lin_y, ang_z
    input  logic                  s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // duty/dir rear_left, duty/dir rear_right, duty/dir front_left,
    // duty/dir front_right
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // is_timeout
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int CNT_W = $clog2(DUTY_BITS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MIX  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DZ_W-1:0]       deadzone_reg;
    logic [TMO_W-1:0]      timeout_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic                  out_free;
    logic                  in_acc;
    logic                  fire;
    wdog_req_t             wreq;
    lane_ctl_t             lctl;
    logic [MAG_W-1:0]      mag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg;
    logic [MAG_W-1:0]      denom;
    logic [DUTY_W-1:0]     duty [NUM_WHEELS];
    logic [DIR_W-1:0]      dir  [NUM_WHEELS];
    logic [OUT_DATA_W-1:0] packed_out;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    assign wreq.tick = in_acc && (s_tuser == OP_TICK);
    assign wreq.cmd  = in_acc && (s_tuser == OP_CMD);
    assign lctl.load = (state_reg == ST_MIX);
    assign lctl.step = (state_reg == ST_DIV);

    mwm_mix #(
        .SPEED_FRAC_BITS(SPEED_FRAC_BITS)
    ) u_mix (
        .clk   (clk),
        .load  (wreq.cmd),
        .lin_x (s_tdata[FIELD_W-1:0]),
        .lin_y (s_tdata[2*FIELD_W-1:FIELD_W]),
        .ang_z (s_tdata[3*FIELD_W-1:2*FIELD_W]),
        .mag   (mag),
        .neg   (neg),
        .denom (denom)
    );

    for (genvar g = 0; g < NUM_WHEELS; g++)
    begin : g_lane
        mwm_lane #(
            .DUTY_BITS(DUTY_BITS)
        ) u_lane (
            .clk      (clk),
            .ctl      (lctl),
            .mag      (mag[g]),
            .neg      (neg[g]),
            .denom    (denom),
            .deadzone (deadzone_reg),
            .duty     (duty[g]),
            .dir      (dir[g])
        );
    end

    mwm_wdog u_wdog (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (wreq),
        .timeout (timeout_reg),
        .fire    (fire)
    );

    always_comb
    begin
        packed_out = '0;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            packed_out[i*WHEEL_W +: DUTY_W]        = duty[i];
            packed_out[i*WHEEL_W + DUTY_W +: DIR_W] = dir[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (wreq.cmd)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                state_next = ST_DIV;
                cnt_next   = CNT_W'(DUTY_BITS - 1);
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (state_reg == ST_DONE && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = packed_out;
            m_tuser_next  = 1'b0;
        end
        else if (fire)
        begin
            // watchdog stop: every wheel brakes at zero duty
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tuser_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            deadzone_reg <= DEADZONE_RST;
            timeout_reg  <= TIMEOUT_RST;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DEADZONE: deadzone_reg <= cfg_wdata[DZ_W-1:0];
                    REG_TIMEOUT:  timeout_reg  <= cfg_wdata[TMO_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: tb/mecanum_wheel_mixer_watchdog_unit_tb.sv
`timescale 1ns / 100ps

module mecanum_wheel_mixer_watchdog_unit_tb;

    import mwm_pkg::*;

    localparam longint FULL_SCALE   = longint'(1) << SPEED_FRAC_BITS_DEF;
    localparam longint DUTY_MAX     = (longint'(1) << DUTY_BITS_DEF) - 1;
    localparam int     SETTLE_CYC   = 16;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     LIMIT_CYCLES = 600000;

    typedef struct packed {
        logic                    op;
        logic signed [FIELD_W-1:0] z;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] x;
    } twist_t;

    // wheel order: rear left, rear right, front left, front right
    typedef struct packed {
        logic                              tmo;
        logic [NUM_WHEELS-1:0][DIR_W-1:0]  dir;
        logic [NUM_WHEELS-1:0][DUTY_W-1:0] duty;
    } wheel_drive_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic                  s_tuser    = OP_CMD;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_DEADZONE;
    logic [CFG_W-1:0]      cfg_wdata  = '0;

    // predictor copy of registers and watchdog state
    logic [DZ_W-1:0]  dz_cfg     = DEADZONE_RST;
    logic [TMO_W-1:0] tmo_cfg    = TIMEOUT_RST;
    int unsigned      elapsed    = 0;
    logic             stop_sent  = 1'b0;

    twist_t       twist_backlog [$];
    wheel_drive_t drives_due [$];
    twist_t       twist_on_bus;
    wheel_drive_t drive_pred;
    wheel_drive_t drive_want;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap      = 0;
    int snk_stall    = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;
    bit hold_taken   = 1'b0;
    int mismatches   = 0;
    int cycles       = 0;
    int mon_w;

    mecanum_wheel_mixer_watchdog_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Returns 1 when the beat produces a result; updates the watchdog state.
    function automatic bit mix_twist(input twist_t tw, output wheel_drive_t res);
        longint sx;
        longint sy;
        longint sz;
        longint sum [NUM_WHEELS];
        longint mg;
        longint peak;
        longint den;
        longint d;
        int     w;
        res = '0;
        for (w = 0; w < NUM_WHEELS; w++)
        begin
            res.dir[w] = DIR_BRAKE;
        end
        if (tw.op == OP_TICK)
        begin
            if (elapsed < 65535)
            begin
                elapsed++;
            end
            if (elapsed > tmo_cfg && !stop_sent)
            begin
                stop_sent = 1'b1;
                res.tmo   = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        sx = $signed(tw.x);
        sy = $signed(tw.y);
        sz = $signed(tw.z);
        sum[0] = sx + sy - sz;
        sum[1] = sx - sy + sz;
        sum[2] = sx - sy - sz;
        sum[3] = sx + sy + sz;
        peak = 0;
        for (w = 0; w < NUM_WHEELS; w++)
        begin
            mg = (sum[w] < 0) ? -sum[w] : sum[w];
            if (mg > peak)
            begin
                peak = mg;
            end
        end
        // normalize only when some wheel passes full scale
        den = (peak > FULL_SCALE) ? peak : FULL_SCALE;
        for (w = 0; w < NUM_WHEELS; w++)
        begin
            mg = (sum[w] < 0) ? -sum[w] : sum[w];
            d  = (mg * DUTY_MAX) / den;
            if (d > DUTY_MAX)
            begin
                d = DUTY_MAX;
            end
            if (sum[w] != 0 && d >= longint'(dz_cfg))
            begin
                res.duty[w] = d[DUTY_W-1:0];
                res.dir[w]  = (sum[w] > 0) ? DIR_FWD : DIR_REV;
            end
        end
        res.tmo   = 1'b0;
        elapsed   = 0;
        stop_sent = 1'b0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_CMD;
            src_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (mix_twist(twist_on_bus, drive_pred))
                begin
                    drives_due.push_back(drive_pred);
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (twist_backlog.size() > 0 && $urandom_range(99) < src_idle_pct)
                begin
                    src_gap  <= $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end
                else if (twist_backlog.size() > 0)
                begin
                    twist_on_bus = twist_backlog.pop_front();
                    s_tdata  <= {twist_on_bus.z, twist_on_bus.y, twist_on_bus.x};
                    s_tuser  <= twist_on_bus.op;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            snk_stall  <= 0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (snk_stall > 0)
        begin
            snk_stall <= snk_stall - 1;
            m_tready  <= 1'b0;
        end
        else if ($urandom_range(99) < snk_idle_pct)
        begin
            snk_stall <= $urandom_range(0, 10);
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drives_due.size() == 0)
            begin
                flag_mismatch("unexpected result beat, m_tdata low bits", 0, m_tdata[31:0]);
            end
            else
            begin
                drive_want = drives_due.pop_front();
                for (mon_w = 0; mon_w < NUM_WHEELS; mon_w++)
                begin
                    if (m_tdata[mon_w*WHEEL_W +: DUTY_W] !== drive_want.duty[mon_w])
                    begin
                        flag_mismatch($sformatf("duty of wheel %0d", mon_w),
                                      drive_want.duty[mon_w],
                                      m_tdata[mon_w*WHEEL_W +: DUTY_W]);
                    end
                    if (m_tdata[mon_w*WHEEL_W+DUTY_W +: DIR_W] !== drive_want.dir[mon_w])
                    begin
                        flag_mismatch($sformatf("dir of wheel %0d", mon_w),
                                      drive_want.dir[mon_w],
                                      m_tdata[mon_w*WHEEL_W+DUTY_W +: DIR_W]);
                    end
                end
                if (m_tuser !== drive_want.tmo)
                begin
                    flag_mismatch("is_timeout", drive_want.tmo, m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("mecanum_wheel_mixer_watchdog_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic push_cmd(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                            input logic [FIELD_W-1:0] z);
        twist_t tw;
        tw.op = OP_CMD;
        tw.x  = x;
        tw.y  = y;
        tw.z  = z;
        twist_backlog.push_back(tw);
    endtask

    task automatic push_ticks(input int n);
        twist_t tw;
        int     i;
        for (i = 0; i < n; i++)
        begin
            tw.op = OP_TICK;
            tw.x  = FIELD_W'($urandom);
            tw.y  = FIELD_W'($urandom);
            tw.z  = FIELD_W'($urandom);
            twist_backlog.push_back(tw);
        end
    endtask

    function automatic logic [FIELD_W-1:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return FIELD_W'($urandom);
            1: return FIELD_W'($urandom_range(0, 8192)) - FIELD_W'(4096);
            2: return FIELD_W'($urandom_range(0, 128)) - FIELD_W'(64);
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'd4096;
                    3: return -16'sd4096;
                    default: return 16'h0000;
                endcase
            end
            4: return FIELD_W'($urandom_range(0, 2800)) - FIELD_W'(1400);
            default: return '0;
        endcase
    endfunction

    // well-formed traffic: commands and tick runs sized to hit the watchdog
    task automatic fill_random(input int n);
        int cnt;
        int len;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(99) < 55)
            begin
                push_cmd(rand_speed(), rand_speed(), rand_speed());
                cnt++;
            end
            else
            begin
                if (tmo_cfg <= 600 && $urandom_range(2) == 0)
                begin
                    len = int'(tmo_cfg) + $urandom_range(0, 3);
                end
                else
                begin
                    len = $urandom_range(1, 6);
                end
                if (len < 1)
                begin
                    len = 1;
                end
                push_ticks(len);
                cnt += len;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (twist_backlog.size() != 0 || s_tvalid || drives_due.size() != 0)
        begin
            @(negedge clk);
        end
        // a trailing tick may still be in flight with no result
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DEADZONE)
        begin
            dz_cfg = val[DZ_W-1:0];
        end
        else
        begin
            tmo_cfg = val[TMO_W-1:0];
        end
    endtask

    task automatic run_phase(input logic [DZ_W-1:0] dz, input logic [TMO_W-1:0] tmo,
                             input int idle_pct, input int n);
        wait_idle();
        write_reg(REG_DEADZONE, CFG_W'(dz));
        write_reg(REG_TIMEOUT, tmo);
        src_idle_pct = idle_pct;
        snk_idle_pct = idle_pct;
        fill_random(n);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 25;
        snk_idle_pct = 25;

        // directed: zero, full scale each axis, saturating mixes, deadzone edge
        push_cmd(16'd0, 16'd0, 16'd0);
        push_cmd(16'd4096, 16'd0, 16'd0);
        push_cmd(-16'sd4096, 16'd0, 16'd0);
        push_cmd(16'd0, 16'd4096, 16'd0);
        push_cmd(16'd0, 16'd0, 16'd4096);
        push_cmd(16'h7fff, 16'h7fff, 16'h7fff);
        push_cmd(16'h8000, 16'h8000, 16'h8000);
        push_cmd(16'h8000, 16'h7fff, 16'h8000);
        push_cmd(16'h7fff, 16'h8000, 16'h0000);
        push_cmd(16'd2048, 16'd2048, 16'd0);
        push_cmd(16'd4097, 16'd0, 16'd0);
        push_cmd(16'd100, 16'd0, 16'd0);
        push_cmd(16'd322, 16'd0, 16'd0);
        push_cmd(16'd321, 16'd0, 16'd0);
        push_cmd(16'd1, 16'd0, 16'd0);
        push_ticks(2);
        push_cmd(16'd0, 16'd16, -16'sd16);
        push_cmd(16'd12345, -16'sd23456, 16'd3456);
        push_cmd(16'hffff, 16'h0001, 16'hffff);
        push_ticks(3);
        // default timeout: one command then enough ticks to trip the watchdog
        push_cmd(rand_speed(), rand_speed(), rand_speed());
        push_ticks(int'(TIMEOUT_RST) + 3);
        fill_random(150);

        run_phase(8'd0, 16'd1, 30, 120);
        hold_req = 1'b1;
        run_phase(8'd255, 16'hffff, 50, 100);
        run_phase(8'($urandom_range(0, 255)), 16'd0, 20, 60);
        run_phase(8'($urandom_range(0, 40)), 16'($urandom_range(2, 30)), 20, 140);
        run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(1, 8)), 0, 90);
        run_phase(DEADZONE_RST, 16'd3, 60, 90);
        run_phase(8'($urandom_range(0, 60)), 16'($urandom_range(1, 12)), 0, 100);

        wait_idle();
        if (drives_due.size() != 0)
        begin
            mismatches += drives_due.size();
        end
        if (mismatches == 0)
        begin
            $display("mecanum_wheel_mixer_watchdog_unit_tb: done, clean");
        end
        else
        begin
            $display("mecanum_wheel_mixer_watchdog_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
